// ===== rtl/fsv_pkg.sv =====
// ----------------------------------------------------------------------------
// fsv_pkg: shared types and step functions of the position string checker
// Holds the transaction payloads, the error codes, the running state and
// the per-byte update functions used by the step logic.
// ----------------------------------------------------------------------------
package fsv_pkg;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_EMPTY       = 4'd1,
    ERR_FIELD_COUNT = 4'd2,
    ERR_RANK_COUNT  = 4'd3,
    ERR_DIGIT       = 4'd4,
    ERR_PIECE       = 4'd5,
    ERR_SQUARES     = 4'd6,
    ERR_SIDE        = 4'd7,
    ERR_CASTLING    = 4'd8,
    ERR_EP_LENGTH   = 4'd9,
    ERR_EP_FILE     = 4'd10,
    ERR_EP_RANK     = 4'd11,
    ERR_HALFMOVE    = 4'd12,
    ERR_FULLMOVE    = 4'd13
  } err_e;

  localparam logic [2:0] FieldPlacement = 3'd1;
  localparam logic [2:0] FieldSide      = 3'd2;
  localparam logic [2:0] FieldCastling  = 3'd3;
  localparam logic [2:0] FieldEnPassant = 3'd4;
  localparam logic [2:0] FieldHalfmove  = 3'd5;
  localparam logic [2:0] FieldFullmove  = 3'd6;
  localparam logic [2:0] FieldMax       = 3'd7;

  localparam logic [3:0] RankCount   = 4'd8;
  localparam logic [3:0] RankSquares = 4'd8;
  localparam logic [3:0] SatMax4     = 4'd15;
  localparam logic [1:0] LenMax      = 2'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       char_present;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [3:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [2:0] field_number;
    logic       inside_field;
    logic       seen_any_char;
    logic [3:0] rank_total;
    logic [3:0] square_total;
    logic       rank_open;
    logic [1:0] field_length;
    logic [7:0] first_field_char;
    logic [7:0] second_field_char;
    logic       castling_bad;
    err_e       pending_error;
  } state_t;

  function automatic err_e f_latch(err_e p, err_e code);
    return (p == ERR_NONE) ? code : p;
  endfunction

  function automatic logic f_is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic f_is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic f_is_piece(logic [7:0] c);
    return (c == "K") || (c == "Q") || (c == "R") || (c == "B") || (c == "N") ||
           (c == "P") || (c == "k") || (c == "q") || (c == "r") || (c == "b") ||
           (c == "n") || (c == "p");
  endfunction

  function automatic state_t f_open_rank(state_t s);
    state_t r;
    r = s;
    if (r.rank_total < SatMax4) r.rank_total = r.rank_total + 4'd1;
    if (r.rank_total > RankCount) r.pending_error = f_latch(r.pending_error, ERR_RANK_COUNT);
    r.rank_open = 1'b1;
    return r;
  endfunction

  function automatic state_t f_close_rank(state_t s);
    state_t r;
    r = s;
    if (r.square_total != RankSquares) r.pending_error = f_latch(r.pending_error, ERR_SQUARES);
    r.square_total = 4'd0;
    r.rank_open    = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] f_add_squares(logic [3:0] t, logic [3:0] n);
    logic [4:0] sum;
    sum = {1'b0, t} + {1'b0, n};
    return (sum > {1'b0, SatMax4}) ? SatMax4 : sum[3:0];
  endfunction

  function automatic state_t f_placement(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    if (c == "/") begin
      if (!r.rank_open) r = f_open_rank(r);
      r = f_close_rank(r);
    end else begin
      if (!r.rank_open) r = f_open_rank(r);
      if (f_is_digit(c)) begin
        // digit value sits in the low nibble of an ASCII digit
        if (c[3:0] < 4'd1 || c[3:0] > 4'd8) begin
          r.pending_error = f_latch(r.pending_error, ERR_DIGIT);
        end else begin
          r.square_total = f_add_squares(r.square_total, c[3:0]);
        end
      end else if (f_is_piece(c)) begin
        r.square_total = f_add_squares(r.square_total, 4'd1);
      end else begin
        r.pending_error = f_latch(r.pending_error, ERR_PIECE);
      end
    end
    return r;
  endfunction

  function automatic state_t f_field_byte(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    if (r.field_length == 2'd0) r.first_field_char = c;
    else if (r.field_length == 2'd1) r.second_field_char = c;
    if (r.field_length < LenMax) r.field_length = r.field_length + 2'd1;
    case (r.field_number)
      FieldPlacement: r = f_placement(r, c);
      FieldCastling: begin
        if (c != "K" && c != "Q" && c != "k" && c != "q") r.castling_bad = 1'b1;
      end
      FieldHalfmove: begin
        if (!f_is_digit(c)) r.pending_error = f_latch(r.pending_error, ERR_HALFMOVE);
      end
      FieldFullmove: begin
        if (!f_is_digit(c)) r.pending_error = f_latch(r.pending_error, ERR_FULLMOVE);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic state_t f_end_field(state_t s);
    state_t r;
    logic   dash;
    r    = s;
    dash = (r.field_length == 2'd1) && (r.first_field_char == "-");
    case (r.field_number)
      FieldPlacement: begin
        if (r.rank_open) r = f_close_rank(r);
        if (r.rank_total != RankCount) r.pending_error = f_latch(r.pending_error, ERR_RANK_COUNT);
      end
      FieldSide: begin
        if (!(r.field_length == 2'd1 &&
              (r.first_field_char == "w" || r.first_field_char == "b"))) begin
          r.pending_error = f_latch(r.pending_error, ERR_SIDE);
        end
      end
      FieldCastling: begin
        if (!dash && r.castling_bad) r.pending_error = f_latch(r.pending_error, ERR_CASTLING);
      end
      FieldEnPassant: begin
        if (!dash) begin
          if (r.field_length != 2'd2) begin
            r.pending_error = f_latch(r.pending_error, ERR_EP_LENGTH);
          end else if (r.first_field_char < "a" || r.first_field_char > "h") begin
            r.pending_error = f_latch(r.pending_error, ERR_EP_FILE);
          end else if (r.second_field_char != "3" && r.second_field_char != "6") begin
            r.pending_error = f_latch(r.pending_error, ERR_EP_RANK);
          end
        end
      end
      default: ;
    endcase
    r.inside_field = 1'b0;
    return r;
  endfunction

  function automatic state_t f_take_byte(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    r.seen_any_char = 1'b1;
    if (f_is_space(c)) begin
      if (r.inside_field) r = f_end_field(r);
    end else begin
      if (!r.inside_field) begin
        if (r.field_number < FieldMax) r.field_number = r.field_number + 3'd1;
        r.inside_field      = 1'b1;
        r.field_length      = 2'd0;
        r.first_field_char  = 8'd0;
        r.second_field_char = 8'd0;
        r.castling_bad      = 1'b0;
        r.rank_total        = 4'd0;
        r.square_total      = 4'd0;
        r.rank_open         = 1'b0;
      end
      r = f_field_byte(r, c);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fsv_chan_if.sv =====
// ----------------------------------------------------------------------------
// fsv_chan_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface fsv_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fen_string_validator_core.sv =====
// ----------------------------------------------------------------------------
// fen_string_validator_core: chess position string syntax checker
// Takes a string a byte per transaction and gives one verdict per string.
//
//   channel  dir  payload                                   transaction
//   in_i     in   character, char_present, end_of_string    one byte / end mark
//   out_o    out  valid_res, error_code                     one verdict
//
// One item per cycle unless a closing item waits on a stalled verdict; the
// single registered step stage sets the rate, and each verdict is registered.
// Reset clears the running state and both valid flags; state also returns
// to reset after each closing item, ready for the next string.
// A stalled verdict holds the stage only when the staged item is a closing
// item; other items keep flowing.
// ----------------------------------------------------------------------------
module fen_string_validator_core (
  input logic                clk_i,
  input logic                rst_ni,
  fsv_chan_if.sink           in_i,
  fsv_chan_if.source         out_o
);

  logic                stage_valid_q;
  fsv_pkg::in_item_t   stage_item_q;
  fsv_pkg::state_t     state_q;
  fsv_pkg::state_t     state_d;
  fsv_pkg::err_e       code;
  logic                out_valid_q;
  fsv_pkg::out_item_t  out_item_q;
  logic                advance;

  fsv_step u_step (
    .state_i (state_q),
    .item_i  (stage_item_q),
    .state_o (state_d),
    .code_o  (code)
  );

  // a closing item needs a free result register to move on
  assign advance = stage_valid_q &&
                   (!stage_item_q.end_of_string || !out_valid_q || out_o.ready);
  assign in_i.ready = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) stage_item_q <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && stage_item_q.end_of_string) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_item_q.end_of_string) begin
      out_item_q.valid_res  <= (code == fsv_pkg::ERR_NONE);
      out_item_q.error_code <= code;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.valid_res == (out_item_q.error_code == fsv_pkg::ERR_NONE)))
    else $error("verdict flag disagrees with error code");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_item_q.end_of_string) |=> (state_q == '0))
    else $error("state not cleared after closing item");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.pending_error != fsv_pkg::ERR_NONE) &&
     !(advance && stage_item_q.end_of_string)) |=> $stable(state_q.pending_error))
    else $error("latched error changed within a string");

  a_fresh_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.seen_any_char |->
      (state_q.field_number == 3'd0 && state_q.pending_error == fsv_pkg::ERR_NONE))
    else $error("state advanced without any byte");

endmodule

// ===== rtl/fsv_step.sv =====
// ----------------------------------------------------------------------------
// fsv_step: next-state and verdict logic for one staged item
// Applies one byte to the running state and, on the closing item, forms
// the verdict and returns the state to its reset value.
// ----------------------------------------------------------------------------
module fsv_step (
  input  fsv_pkg::state_t   state_i,
  input  fsv_pkg::in_item_t item_i,
  output fsv_pkg::state_t   state_o,
  output fsv_pkg::err_e     code_o
);

  fsv_pkg::state_t after_byte;
  fsv_pkg::state_t closed;

  always_comb begin
    after_byte = state_i;
    if (item_i.char_present) after_byte = fsv_pkg::f_take_byte(state_i, item_i.character);
    closed = after_byte;
    if (after_byte.inside_field) closed = fsv_pkg::f_end_field(after_byte);
  end

  // empty string first, then field count, then the first content error
  always_comb begin
    if (!closed.seen_any_char) begin
      code_o = fsv_pkg::ERR_EMPTY;
    end else if (closed.field_number != fsv_pkg::FieldFullmove) begin
      code_o = fsv_pkg::ERR_FIELD_COUNT;
    end else begin
      code_o = closed.pending_error;
    end
  end

  assign state_o = item_i.end_of_string ? '0 : after_byte;

endmodule
